// ----- sv/autocorrelation_engine_top_defines.svh -----
// assertion macros for the autocorrelation engine
`ifndef AUTOCORRELATION_ENGINE_TOP_DEFINES_SVH
`define AUTOCORRELATION_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define ACORR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define ACORR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/acorr_pkg.sv -----
// shared types and constants for the autocorrelation engine
package acorr_pkg;

   localparam int MAX_LEN_DEF = 64;
   localparam int SAMPLE_W    = 16;
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int VALUE_W     = 38;
   localparam int INDEX_W     = 6;
   localparam int RSP_FIELD_W = VALUE_W + INDEX_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_DRAIN
   } acorr_state_type;

endpackage

// ----- sv/autocorrelation_engine_top.sv -----
// autocorrelation engine: coefficient store, shared multiply-accumulate and sequencer
//
//   channel | ports        | direction | contents
//   req     | req_t*       | in        | tdata[15:0] sample, tlast last_sample
//   rsp     | rsp_t*       | out       | tdata[37:0] lag_value, [43:38] lag_index,
//           |              |           | tlast last_lag, tuser truncated
//
// one sample beat is taken per cycle while loading
// after the last beat, lag t issues (n - t) products and then waits for the
// multiply pipeline to drain before its result beat is stored
// one shared 16x16 multiplier feeds a 38-bit accumulator
// a stalled result beat holds the sequencer before the next lag is stored
// synchronous reset, no clearing pass; store entries are read only once written
`include "autocorrelation_engine_top_defines.svh"

module autocorrelation_engine_top #(
   parameter int MAX_LEN = acorr_pkg::MAX_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [acorr_pkg::SAMPLE_W-1:0]   req_tdata,   // sample
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [acorr_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // lag_value, lag_index, zero pad
   output logic                             rsp_tlast,
   output logic                             rsp_tuser    // truncated
);

   import acorr_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   acorr_state_type state_ff, state_in;

   logic [CW-1:0]          count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [AW-1:0]          lag_ff, lag_in;
   logic [AW-1:0]          ptr_a_ff, ptr_a_in;
   logic [AW-1:0]          ptr_b_ff, ptr_b_in;
   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [VALUE_W-1:0] acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_trunc_ff, rsp_trunc_in;

   logic                   req_fire;
   logic                   store_full;
   logic                   wr_en;
   logic                   issue;
   logic                   last_issue;
   logic                   last_lag;
   logic                   emit;
   logic signed [SAMPLE_W-1:0] rd_a;
   logic signed [SAMPLE_W-1:0] rd_b;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign store_full = (count_ff == CW'(MAX_LEN));
   assign wr_en      = req_fire && !store_full;
   assign issue      = (state_ff == ST_ISSUE);
   assign last_issue = ((CW'(ptr_a_ff) + CW'(1)) == count_ff);
   assign last_lag   = ((CW'(lag_ff) + CW'(1)) == count_ff);

   acorr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_data   (req_tdata),
      .rd_addr_a (ptr_a_ff),
      .rd_data_a (rd_a),
      .rd_addr_b (ptr_b_ff),
      .rd_data_b (rd_b)
   );

   // product and accumulate stages
   always_comb begin
      v1_in   = issue;
      v2_in   = v1_ff;
      prod_in = rd_a * rd_b;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      lag_in       = lag_ff;
      ptr_a_in     = ptr_a_ff;
      ptr_b_in     = ptr_b_ff;
      acc_in       = acc_ff;
      emit         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;

      if (v2_ff) begin
         acc_in = acc_ff + {{(VALUE_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (store_full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (req_tlast) begin
                  state_in = ST_ISSUE;
                  lag_in   = '0;
                  ptr_a_in = '0;
                  ptr_b_in = '0;
                  acc_in   = '0;
               end
            end
         end
         ST_ISSUE: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_a_in = ptr_a_ff + AW'(1);
               ptr_b_in = ptr_b_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && (!rsp_valid_ff || rsp_tready)) begin
               emit         = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({INDEX_W'(lag_ff), acc_ff});
               rsp_last_in  = last_lag;
               rsp_trunc_in = ovf_ff;
               acc_in       = '0;
               if (last_lag) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  state_in = ST_ISSUE;
                  lag_in   = lag_ff + AW'(1);
                  ptr_a_in = lag_ff + AW'(1);
                  ptr_b_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lag_ff       <= lag_in;
      ptr_a_ff     <= ptr_a_in;
      ptr_b_ff     <= ptr_b_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_trunc_ff;

   `ACORR_ASSERT_NOW(a_rd_in_range, clock, reset, state_ff == ST_ISSUE, CW'(ptr_a_ff) < count_ff, "read beyond stored coefficients")
   `ACORR_ASSERT_NOW(a_ptr_gap, clock, reset, state_ff == ST_ISSUE, ptr_a_ff == (ptr_b_ff + lag_ff), "read pointers not one lag apart")
   `ACORR_ASSERT_NOW(a_idle_empty, clock, reset, state_ff == ST_LOAD, !v1_ff && !v2_ff, "products in flight while loading")
   `ACORR_ASSERT_NEXT(a_emit_beat, clock, reset, emit, rsp_valid_ff && (acc_ff == '0), "lag result not stored")

endmodule

// ----- sv/acorr_ram.sv -----
// generic single-write, dual-read ram with registered read data
module acorr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule
